@@ rtl/adv_pkg.sv @@
// ----------------------------------------------------------------------------
// adv_pkg
// Shared constants, register indexes and types of the 2D advection stencil.
// ----------------------------------------------------------------------------
package adv_pkg;

	localparam int unsigned VAL_W      = 32;
	localparam int unsigned STEP_W     = 31;
	localparam int unsigned SIZE_W     = 10;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam int unsigned MAX_COLS = 512;
	localparam int unsigned MAX_ROWS = 512;
	localparam int unsigned LS_DEPTH = MAX_COLS + 2;
	localparam int unsigned COL_W    = $clog2(MAX_COLS + 2);
	localparam int unsigned ROW_W    = $clog2(MAX_ROWS + 2);

	localparam int unsigned FIFO_DEPTH = 16;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned CRD_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_FLUX_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_OVER_DX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_OVER_DY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE  = 3'd5;

	localparam logic              RST_FLUX_MODE = 1'b0;
	localparam logic [VAL_W-1:0]  RST_VELOCITY  = 32'd65536;
	localparam logic [STEP_W-1:0] RST_STEP      = 31'd32768;
	localparam logic [SIZE_W-1:0] RST_SIZE      = 10'd512;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic vld;
		logic last;
	} tag_t;

endpackage

@@ rtl/adv_in_if.sv @@
// ----------------------------------------------------------------------------
// adv_in_if
// Input stream of padded-grid cells, valid/ready handshake.
// ----------------------------------------------------------------------------
interface adv_in_if import adv_pkg::*; ();

	logic valid;
	logic ready;
	val_t cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink (input valid, input cell_value, output ready);

endinterface

@@ rtl/adv_out_if.sv @@
// ----------------------------------------------------------------------------
// adv_out_if
// Output stream of updated interior cells, valid/ready handshake.
// ----------------------------------------------------------------------------
interface adv_out_if import adv_pkg::*; ();

	logic valid;
	logic ready;
	val_t new_value;
	logic last;

	modport source (output valid, output new_value, output last, input ready);
	modport sink (input valid, input new_value, input last, output ready);

endinterface

@@ rtl/adv_ram.sv @@
// ----------------------------------------------------------------------------
// adv_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module adv_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/adv_calc.sv @@
// ----------------------------------------------------------------------------
// adv_calc
// Flux and update pipeline: face sums, four flux multipliers, differences,
// step terms split in two partial products, final sum with saturation.
// ----------------------------------------------------------------------------
module adv_calc import adv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              flux_mode,
	input  val_t              velocity,
	input  logic [STEP_W-1:0] step_over_dx,
	input  logic [STEP_W-1:0] step_over_dy,
	input  tag_t              tag_in,
	input  val_t              uw,
	input  val_t              uc,
	input  val_t              ue,
	input  val_t              us,
	input  val_t              un,
	output tag_t              tag_out,
	output val_t              value
);

	localparam logic signed [64:0] RND_POS = 65'sd65536;
	localparam logic signed [64:0] RND_NEG = 65'sd65535;
	localparam logic [63:0]        CLAMP   = 64'h0000_0100_0000_0000;
	localparam logic signed [43:0] SAT_MAX = 44'sh000_7FFF_FFFF;
	localparam logic signed [43:0] SAT_MIN = -44'sh000_8000_0000;

	function automatic logic signed [32:0] face_sum(input logic mode, input logic vpos,
		input val_t a, input val_t b);
		logic signed [32:0] ae;
		logic signed [32:0] be;
		ae = $signed({a[VAL_W-1], a});
		be = $signed({b[VAL_W-1], b});
		if (mode) begin
			return ae + be;
		end else if (vpos) begin
			return ae + ae;
		end else begin
			return be + be;
		end
	endfunction

	logic vpos;
	assign vpos = !velocity[VAL_W-1] && (velocity != '0);

	// faces: 0 west, 1 east, 2 south, 3 north
	logic signed [32:0] sum_s2 [4];
	logic signed [64:0] prod_s3 [4];
	logic signed [47:0] flux_s4 [4];
	logic signed [48:0] dx_s5, dy_s5;
	logic [47:0]        magx_s6, magy_s6;
	logic               negx_s6, negy_s6;
	logic [46:0]        phx_s7, phy_s7;
	logic [62:0]        plx_s7, ply_s7;
	logic               negx_s7, negy_s7;
	logic [40:0]        tx_s8, ty_s8;
	logic               negx_s8, negy_s8;
	val_t               uc_s2, uc_s3, uc_s4, uc_s5, uc_s6, uc_s7, uc_s8;
	val_t               value_s9;
	tag_t               tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8, tag_s9;

	logic [63:0]        rx, ry;
	logic signed [43:0] sx, sy, tot;
	val_t               sat;

	always_comb begin
		rx = {1'b0, phx_s7, 16'b0} + 64'((plx_s7 + 63'd32768) >> 16);
		ry = {1'b0, phy_s7, 16'b0} + 64'((ply_s7 + 63'd32768) >> 16);
	end

	always_comb begin
		sx  = negx_s8 ? -$signed({3'b0, tx_s8}) : $signed({3'b0, tx_s8});
		sy  = negy_s8 ? -$signed({3'b0, ty_s8}) : $signed({3'b0, ty_s8});
		tot = $signed({{12{uc_s8[VAL_W-1]}}, uc_s8}) - sx - sy;
		if (tot > SAT_MAX) begin
			sat = 32'sh7FFF_FFFF;
		end else if (tot < SAT_MIN) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = tot[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		sum_s2[0] <= face_sum(flux_mode, vpos, uw, uc);
		sum_s2[1] <= face_sum(flux_mode, vpos, uc, ue);
		sum_s2[2] <= face_sum(flux_mode, vpos, us, uc);
		sum_s2[3] <= face_sum(flux_mode, vpos, uc, un);
		for (int i = 0; i < 4; i++) begin
			prod_s3[i] <= 65'(velocity) * 65'(sum_s2[i]);
			flux_s4[i] <= 48'((prod_s3[i] + (prod_s3[i][64] ? RND_NEG : RND_POS)) >>> 17);
		end
		dx_s5   <= 49'(flux_s4[1]) - 49'(flux_s4[0]);
		dy_s5   <= 49'(flux_s4[3]) - 49'(flux_s4[2]);
		negx_s6 <= dx_s5[48];
		negy_s6 <= dy_s5[48];
		magx_s6 <= dx_s5[48] ? 48'(-dx_s5) : 48'(dx_s5);
		magy_s6 <= dy_s5[48] ? 48'(-dy_s5) : 48'(dy_s5);
		phx_s7  <= 47'(magx_s6[47:32]) * 47'(step_over_dx);
		plx_s7  <= 63'(magx_s6[31:0]) * 63'(step_over_dx);
		phy_s7  <= 47'(magy_s6[47:32]) * 47'(step_over_dy);
		ply_s7  <= 63'(magy_s6[31:0]) * 63'(step_over_dy);
		negx_s7 <= negx_s6;
		negy_s7 <= negy_s6;
		tx_s8   <= (rx > CLAMP) ? CLAMP[40:0] : rx[40:0];
		ty_s8   <= (ry > CLAMP) ? CLAMP[40:0] : ry[40:0];
		negx_s8 <= negx_s7;
		negy_s8 <= negy_s7;
		value_s9 <= sat;
		uc_s2 <= uc;
		uc_s3 <= uc_s2;
		uc_s4 <= uc_s3;
		uc_s5 <= uc_s4;
		uc_s6 <= uc_s5;
		uc_s7 <= uc_s6;
		uc_s8 <= uc_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
			tag_s8 <= '0;
			tag_s9 <= '0;
		end else begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
			tag_s9 <= tag_s8;
		end
	end

	assign tag_out = tag_s9;
	assign value   = value_s9;

endmodule

@@ rtl/advection_stencil_update_2d_top.sv @@
// ----------------------------------------------------------------------------
// advection_stencil_update_2d_top
// One time step of first-order upwind or central finite-volume advection on
// a streamed padded grid, with line stores in one RAM and a result queue.
// ----------------------------------------------------------------------------
// path: each result passes the stage-1 registers, adv_calc pipeline and queue
// throughput: one cell per cycle, set by the line-store RAM doing one read and
// one write-back per cycle; ready drops only when the 16-entry result queue
// has all its slots reserved
// reset: counters, window, queue and credits clear at once, registers take
// their defaults; the line stores are not cleared and no clearing pass runs
module advection_stencil_update_2d_top import adv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	adv_in_if.sink                cells,
	adv_out_if.source             results
);

	function automatic int unsigned eff_last(input logic [SIZE_W-1:0] sz,
		input int unsigned mx);
		int unsigned s;
		s = 32'(sz);
		if (s == 0) begin
			s = 1;
		end else if (s > mx) begin
			s = mx;
		end
		return s + 1;
	endfunction

	// configuration registers
	logic              flux_mode_q;
	val_t              velocity_q;
	logic [STEP_W-1:0] step_dx_q, step_dy_q;
	logic [SIZE_W-1:0] cols_q, rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flux_mode_q <= RST_FLUX_MODE;
			velocity_q  <= RST_VELOCITY;
			step_dx_q   <= RST_STEP;
			step_dy_q   <= RST_STEP;
			cols_q      <= RST_SIZE;
			rows_q      <= RST_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FLUX_MODE:    flux_mode_q <= cfg_data[0];
				REG_VELOCITY:     velocity_q  <= cfg_data[VAL_W-1:0];
				REG_STEP_OVER_DX: step_dx_q   <= cfg_data[STEP_W-1:0];
				REG_STEP_OVER_DY: step_dy_q   <= cfg_data[STEP_W-1:0];
				REG_COLS_IN_USE:  cols_q      <= cfg_data[SIZE_W-1:0];
				REG_ROWS_IN_USE:  rows_q      <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// scan position
	logic [COL_W-1:0] col_q, wlast;
	logic [ROW_W-1:0] row_q, hlast;
	logic             in_xfer, out_xfer, has_res, is_last;

	assign wlast    = COL_W'(eff_last(cols_q, MAX_COLS));
	assign hlast    = ROW_W'(eff_last(rows_q, MAX_ROWS));
	assign in_xfer  = cells.valid && cells.ready;
	assign out_xfer = results.valid && results.ready;
	assign has_res  = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2)) &&
		(row_q <= hlast) && (col_q <= wlast);
	assign is_last  = (row_q == hlast) && (col_q == wlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (col_q >= wlast) begin
				col_q <= '0;
				row_q <= (row_q >= hlast) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// stage 1: line-store read returns, write-back of the shifted column
	logic             acc_s1;
	tag_t             tag_s1;
	val_t             x_s1;
	logic [COL_W-1:0] addr_s1;
	logic [2*VAL_W-1:0] ram_rdata;
	val_t             rd_prev, rd_older;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
			tag_s1 <= '0;
		end else begin
			acc_s1 <= in_xfer;
			tag_s1 <= '{vld: in_xfer && has_res, last: is_last};
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_s1    <= cells.cell_value;
			addr_s1 <= col_q;
		end
	end

	adv_ram #(
		.WIDTH (2 * VAL_W),
		.DEPTH (LS_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (acc_s1),
		.waddr (addr_s1),
		.wdata ({x_s1, rd_prev}),
		.re    (in_xfer),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	assign rd_prev  = ram_rdata[2*VAL_W-1:VAL_W];
	assign rd_older = ram_rdata[VAL_W-1:0];

	// window over the row above plus the south and north neighbours
	val_t win0_q, win1_q, win2_q, south_q, north_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q  <= '0;
			win1_q  <= '0;
			win2_q  <= '0;
			south_q <= '0;
			north_q <= '0;
		end else if (acc_s1) begin
			win0_q  <= win1_q;
			win1_q  <= win2_q;
			win2_q  <= rd_prev;
			south_q <= rd_older;
			north_q <= x_s1;
		end
	end

	tag_t calc_tag;
	val_t calc_value;

	adv_calc u_calc (
		.clk          (clk),
		.arst_n       (arst_n),
		.flux_mode    (flux_mode_q),
		.velocity     (velocity_q),
		.step_over_dx (step_dx_q),
		.step_over_dy (step_dy_q),
		.tag_in       ('{vld: acc_s1 && tag_s1.vld, last: tag_s1.last}),
		.uw           (win1_q),
		.uc           (win2_q),
		.ue           (rd_prev),
		.us           (south_q),
		.un           (north_q),
		.tag_out      (calc_tag),
		.value        (calc_value)
	);

	// result queue with credits reserved at input transfer
	logic [VAL_W:0]   fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CRD_W-1:0] fifo_cnt_q, credit_q;
	logic             reserve;

	assign reserve     = in_xfer && has_res;
	assign cells.ready = credit_q < CRD_W'(FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (calc_tag.vld) begin
			fifo_q[wr_ptr_q] <= {calc_tag.last, calc_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			credit_q   <= '0;
		end else begin
			if (calc_tag.vld) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (out_xfer) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + CRD_W'(calc_tag.vld) - CRD_W'(out_xfer);
			credit_q   <= credit_q + CRD_W'(reserve) - CRD_W'(out_xfer);
		end
	end

	assign results.valid     = fifo_cnt_q != '0;
	assign results.new_value = fifo_q[rd_ptr_q][VAL_W-1:0];
	assign results.last      = fifo_q[rd_ptr_q][VAL_W];

	assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CRD_W'(FIFO_DEPTH))
		else $error("result credits exceed queue depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= credit_q)
		else $error("queue holds results without credit");

	assert property (@(posedge clk) disable iff (!arst_n)
		calc_tag.vld |-> fifo_cnt_q != CRD_W'(FIFO_DEPTH))
		else $error("result written into full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(reserve && !out_xfer) |=> credit_q == $past(credit_q) + CRD_W'(1))
		else $error("credit not taken for interior cell");

	assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(MAX_COLS + 1))
		else $error("column counter beyond padded row");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2D advection stencil update. A plan of padded
// grid cells and register writes is built up front and streamed in bursts;
// a bit-accurate stencil predictor turns every accepted interior cell into the
// expected updated value, and the result stream is checked in order.
// ----------------------------------------------------------------------------
module tb;
	import adv_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned DRAIN_QUIET = 16;
	localparam int unsigned SMALL_CELLS = 1500;
	localparam longint unsigned TERM_CLAMP = 64'h100_0000_0000;
	localparam longint VAL_MAX = 64'sd2147483647;
	localparam longint VAL_MIN = -64'sd2147483648;

	// corner frames of the directed part, 3x3 padded cells each
	localparam logic [9*VAL_W-1:0] SAT_FRAME = {
		32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
		32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
	localparam logic [9*VAL_W-1:0] NEG_FRAME = {
		32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
		32'h0000_0000, 32'h8000_0000, 32'h0001_0000};
	localparam logic [9*VAL_W-1:0] AVG_FRAME = {
		32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000,
		32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000,
		32'hFFFF_0000, 32'h7FFF_0000, 32'h0000_FFFF};

	typedef enum logic [1:0] {
		OP_CELL,
		OP_REG,
		OP_DRAIN
	} plan_kind_e;

	typedef struct {
		plan_kind_e            kind;
		val_t                  value;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} plan_op_t;

	typedef struct {
		val_t new_value;
		logic last;
	} grid_update_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	adv_in_if  cells_if ();
	adv_out_if results_if ();

	advection_stencil_update_2d_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cells     (cells_if),
		.results   (results_if)
	);

	plan_op_t     cell_plan[$];
	grid_update_t pending_updates[$];

	// stencil predictor state
	logic            cfg_central;
	longint          cfg_vel;
	longint unsigned cfg_dx;
	longint unsigned cfg_dy;
	int unsigned     cfg_cols;
	int unsigned     cfg_rows;
	val_t            ls_prev [LS_DEPTH];
	val_t            ls_older [LS_DEPTH];
	val_t            win [3];
	val_t            dly_south;
	val_t            dly_north;
	int unsigned     grid_col;
	int unsigned     grid_row;

	// plan-side tracking of the raster position
	int unsigned g_cols;
	int unsigned g_rows;
	int unsigned g_col;
	int unsigned g_row;
	int unsigned planned_cells;

	int unsigned quiet_left;
	int unsigned gap_left;
	int unsigned burst_left;
	logic [15:0] stall_pat;
	logic [3:0]  stall_pos;

	int unsigned err_cnt;
	int unsigned cells_sent;
	int unsigned updates_checked;
	int unsigned frames_done;
	int unsigned reg_writes;

	always #10 clk = ~clk;

	function automatic int unsigned eff_size(int unsigned v, int unsigned lim);
		return (v == 0) ? 1 : ((v > lim) ? lim : v);
	endfunction

	function automatic longint unsigned mag(longint x);
		return (x < 0) ? $unsigned(-x) : $unsigned(x);
	endfunction

	function automatic longint face_flux(longint a, longint b);
		longint s;
		longint unsigned m;
		if (cfg_central)
			s = a + b;
		else if (cfg_vel > 0)
			s = 2 * a;
		else
			s = 2 * b;
		m = (mag(cfg_vel) * mag(s) + 64'd65536) >> 17;
		return ((cfg_vel < 0) != (s < 0)) ? -$signed(m) : $signed(m);
	endfunction

	function automatic longint scaled_diff(longint d, longint unsigned k);
		longint unsigned md;
		longint unsigned r;
		md = mag(d);
		r = (((md >> 32) * k) << 16) + (((md & 64'hFFFF_FFFF) * k + 64'd32768) >> 16);
		if (r > TERM_CLAMP)
			r = TERM_CLAMP;
		return (d < 0) ? -$signed(r) : $signed(r);
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_FLUX_MODE:    cfg_central = data[0];
			REG_VELOCITY:     cfg_vel = val_t'(data);
			REG_STEP_OVER_DX: cfg_dx = data[STEP_W-1:0];
			REG_STEP_OVER_DY: cfg_dy = data[STEP_W-1:0];
			REG_COLS_IN_USE:  cfg_cols = data[SIZE_W-1:0];
			REG_ROWS_IN_USE:  cfg_rows = data[SIZE_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void stencil_step(val_t x);
		int unsigned  wlast;
		int unsigned  hlast;
		int unsigned  c;
		int unsigned  r;
		val_t         above;
		val_t         older;
		longint       uw, uc, ue, us, un, res;
		grid_update_t upd;
		wlast = eff_size(cfg_cols, MAX_COLS) + 1;
		hlast = eff_size(cfg_rows, MAX_ROWS) + 1;
		c = grid_col;
		r = grid_row;
		above = ls_prev[c];
		older = ls_older[c];
		ls_older[c] = above;
		ls_prev[c] = x;
		win[0] = win[1];
		win[1] = win[2];
		win[2] = above;
		if (r >= 2 && c >= 2 && r <= hlast && c <= wlast) begin
			uw = win[0];
			uc = win[1];
			ue = win[2];
			us = dly_south;
			un = dly_north;
			res = uc - scaled_diff(face_flux(uc, ue) - face_flux(uw, uc), cfg_dx)
				- scaled_diff(face_flux(uc, un) - face_flux(us, uc), cfg_dy);
			if (res > VAL_MAX)
				res = VAL_MAX;
			if (res < VAL_MIN)
				res = VAL_MIN;
			upd.new_value = val_t'(res[VAL_W-1:0]);
			upd.last = (r == hlast && c == wlast);
			pending_updates.push_back(upd);
		end
		dly_south = older;
		dly_north = x;
		if (c >= wlast) begin
			grid_col = 0;
			grid_row = (r >= hlast) ? 0 : r + 1;
		end else begin
			grid_col = c + 1;
		end
	endfunction

	function automatic void plan_cell(val_t v);
		plan_op_t    op;
		int unsigned wl;
		int unsigned hl;
		op.kind = OP_CELL;
		op.value = v;
		op.idx = '0;
		op.data = '0;
		cell_plan.push_back(op);
		planned_cells++;
		wl = eff_size(g_cols, MAX_COLS) + 1;
		hl = eff_size(g_rows, MAX_ROWS) + 1;
		if (g_col >= wl) begin
			g_col = 0;
			g_row = (g_row >= hl) ? 0 : g_row + 1;
		end else begin
			g_col++;
		end
	endfunction

	function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		plan_op_t op;
		op.value = '0;
		op.idx = idx;
		op.data = data;
		if (cell_plan.size() == 0 || cell_plan[$].kind == OP_CELL) begin
			op.kind = OP_DRAIN;
			cell_plan.push_back(op);
		end
		op.kind = OP_REG;
		cell_plan.push_back(op);
		if (idx == REG_COLS_IN_USE)
			g_cols = data[SIZE_W-1:0];
		if (idx == REG_ROWS_IN_USE)
			g_rows = data[SIZE_W-1:0];
	endfunction

	function automatic val_t rand_cell(int unsigned style, val_t base);
		if (style == 0)
			return val_t'($urandom);
		if (style == 1)
			return base + val_t'($urandom_range(0, 262143)) - val_t'(131072);
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return val_t'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_velocity();
		case ($urandom_range(0, 6))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return $urandom;
			default: return $urandom_range(0, 262144) - 131072;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_step();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 32'h7FFF_FFFF;
			2: return $urandom & 32'h7FFF_FFFF;
			default: return $urandom_range(0, 131072);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_size(int unsigned big);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom_range(9, big);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		case ($urandom_range(0, 7))
			0, 1, 2, 3: return 0;
			4, 5: return $urandom_range(1, 3);
			6: return $urandom_range(4, 8);
			default: return $urandom_range(9, 20);
		endcase
	endfunction

	// sender: bursts of cells, register writes once the block has gone quiet
	always @(posedge clk) begin
		logic                  take;
		logic                  nxt_valid;
		logic                  nxt_we;
		val_t                  nxt_cell;
		logic [CFG_IDX_W-1:0]  nxt_idx;
		logic [CFG_DATA_W-1:0] nxt_data;
		plan_op_t              op;
		take = cells_if.valid && cells_if.ready;
		nxt_valid = 1'b0;
		nxt_we = 1'b0;
		nxt_cell = cells_if.cell_value;
		nxt_idx = cfg_index;
		nxt_data = cfg_data;
		if (arst_n) begin
			if (take) begin
				stencil_step(cells_if.cell_value);
				cells_sent++;
			end
			if (cells_if.valid && !take) begin
				nxt_valid = 1'b1;
			end else if (quiet_left != 0) begin
				quiet_left--;
			end else if (gap_left != 0) begin
				gap_left--;
			end else if (cell_plan.size() != 0) begin
				op = cell_plan[0];
				case (op.kind)
					OP_CELL: begin
						nxt_valid = 1'b1;
						nxt_cell = op.value;
						void'(cell_plan.pop_front());
						if (burst_left > 1) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(1, 40);
							gap_left = pick_gap();
						end
					end
					OP_REG: begin
						nxt_we = 1'b1;
						nxt_idx = op.idx;
						nxt_data = op.data;
						apply_reg(op.idx, op.data);
						reg_writes++;
						void'(cell_plan.pop_front());
					end
					default: begin
						if (pending_updates.size() == 0) begin
							quiet_left = DRAIN_QUIET;
							void'(cell_plan.pop_front());
						end
					end
				endcase
			end
		end
		cells_if.valid <= nxt_valid;
		cells_if.cell_value <= nxt_cell;
		cfg_we <= nxt_we;
		cfg_index <= nxt_idx;
		cfg_data <= nxt_data;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (stall_pos == 0) begin
			case ($urandom_range(0, 7))
				0, 1, 2: stall_pat = '1;
				3: stall_pat = '0;
				default: stall_pat = $urandom;
			endcase
		end
		results_if.ready <= stall_pat[stall_pos];
		stall_pos = stall_pos + 1'b1;
	end

	// result checker
	always @(posedge clk) begin
		grid_update_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_updates.size() == 0) begin
				err_cnt++;
				if (err_cnt < 50)
					$display("%0t: unexpected transfer, expected none, actual new_value %h last %b",
						$time, results_if.new_value, results_if.last);
			end else begin
				want = pending_updates.pop_front();
				updates_checked++;
				if (results_if.new_value !== want.new_value) begin
					err_cnt++;
					if (err_cnt < 50)
						$display("%0t: new_value mismatch, expected %h, actual %h",
							$time, want.new_value, results_if.new_value);
				end
				if (results_if.last !== want.last) begin
					err_cnt++;
					if (err_cnt < 50)
						$display("%0t: last mismatch, expected %b, actual %b",
							$time, want.last, results_if.last);
				end
				if (want.last)
					frames_done++;
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int unsigned style;
		int unsigned total;
		int unsigned mark;
		int unsigned iter;
		int unsigned wait_cnt;
		logic        wide;
		val_t        base;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cells_if.valid = 1'b0;
		cells_if.cell_value = '0;
		results_if.ready = 1'b0;

		cfg_central = RST_FLUX_MODE;
		cfg_vel = RST_VELOCITY;
		cfg_dx = RST_STEP;
		cfg_dy = RST_STEP;
		cfg_cols = RST_SIZE;
		cfg_rows = RST_SIZE;
		for (int i = 0; i < LS_DEPTH; i++) begin
			ls_prev[i] = '0;
			ls_older[i] = '0;
		end
		win[0] = '0;
		win[1] = '0;
		win[2] = '0;
		dly_south = '0;
		dly_north = '0;
		grid_col = 0;
		grid_row = 0;
		g_cols = RST_SIZE;
		g_rows = RST_SIZE;
		g_col = 0;
		g_row = 0;
		planned_cells = 0;
		quiet_left = 0;
		gap_left = 0;
		burst_left = 0;
		stall_pat = '1;
		stall_pos = '0;
		err_cnt = 0;
		cells_sent = 0;
		updates_checked = 0;
		frames_done = 0;
		reg_writes = 0;

		// saturation with the fastest positive flow
		plan_reg(REG_COLS_IN_USE, 1);
		plan_reg(REG_ROWS_IN_USE, 1);
		plan_reg(REG_FLUX_MODE, 0);
		plan_reg(REG_VELOCITY, 32'h7FFF_FFFF);
		plan_reg(REG_STEP_OVER_DX, 32'h7FFF_FFFF);
		plan_reg(REG_STEP_OVER_DY, 32'h7FFF_FFFF);
		for (int i = 0; i < 9; i++)
			plan_cell(SAT_FRAME[i*VAL_W +: VAL_W]);
		// most negative velocity takes the other side
		plan_reg(REG_VELOCITY, 32'h8000_0000);
		plan_reg(REG_STEP_OVER_DX, 32'h0001_0000);
		plan_reg(REG_STEP_OVER_DY, 32'h0000_4000);
		for (int i = 0; i < 9; i++)
			plan_cell(NEG_FRAME[i*VAL_W +: VAL_W]);
		// central flux, still flow, zero sizes act as one
		plan_reg(REG_FLUX_MODE, 1);
		plan_reg(REG_VELOCITY, 0);
		plan_reg(REG_COLS_IN_USE, 0);
		plan_reg(REG_ROWS_IN_USE, 0);
		plan_reg(REG_STEP_OVER_DX, 0);
		for (int i = 0; i < 9; i++)
			plan_cell(AVG_FRAME[i*VAL_W +: VAL_W]);

		iter = 0;
		mark = planned_cells;
		while (planned_cells - mark < SMALL_CELLS) begin
			iter++;
			style = $urandom_range(0, 2);
			base = val_t'($urandom);
			if (iter == 6) begin
				// widest or tallest grid, sizes above the maximum clip to it
				wide = $urandom_range(0, 1);
				plan_reg(REG_FLUX_MODE, $urandom_range(0, 1));
				plan_reg(REG_VELOCITY, rand_velocity());
				plan_reg(REG_COLS_IN_USE, wide ? 1023 : 1);
				plan_reg(REG_ROWS_IN_USE, wide ? 1 : 600);
				do
					plan_cell(rand_cell(style, base));
				while (g_col != 0 || g_row != 0);
				continue;
			end
			if ($urandom_range(0, 1))
				plan_reg(REG_FLUX_MODE, $urandom_range(0, 1));
			if ($urandom_range(0, 1))
				plan_reg(REG_VELOCITY, rand_velocity());
			if ($urandom_range(0, 2) == 0)
				plan_reg(REG_STEP_OVER_DX, rand_step());
			if ($urandom_range(0, 2) == 0)
				plan_reg(REG_STEP_OVER_DY, rand_step());
			if (iter == 1 || $urandom_range(0, 1))
				plan_reg(REG_COLS_IN_USE, rand_size(40));
			if (iter == 1 || $urandom_range(0, 1))
				plan_reg(REG_ROWS_IN_USE, rand_size(16));
			if ($urandom_range(0, 4) == 0) begin
				// resize mid-frame: columns never grow so no stale store entry is read
				total = (eff_size(g_cols, MAX_COLS) + 2) * (eff_size(g_rows, MAX_ROWS) + 2);
				repeat ($urandom_range(1, total - 1))
					plan_cell(rand_cell(style, base));
				if ($urandom_range(0, 1))
					plan_reg(REG_COLS_IN_USE, $urandom_range(0, eff_size(g_cols, MAX_COLS)));
				else
					plan_reg(REG_ROWS_IN_USE, $urandom_range(0, 12));
				while (g_col != 0 || g_row != 0)
					plan_cell(rand_cell(style, base));
			end else begin
				do
					plan_cell(rand_cell(style, base));
				while (g_col != 0 || g_row != 0);
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (cell_plan.size() != 0 || cells_if.valid);
		wait_cnt = 0;
		while (pending_updates.size() != 0 && wait_cnt < 5000) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (20) @(negedge clk);
		if (pending_updates.size() != 0) begin
			err_cnt += pending_updates.size();
			$display("%0t: %0d expected updates never arrived", $time, pending_updates.size());
		end

		$display("covered %0d cells in %0d complete frames, %0d updates checked, %0d register writes",
			cells_sent, frames_done, updates_checked, reg_writes);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
